// ----- rtl/sclt_pkg.sv -----
// types, codes and helpers shared by the command-line tokenizer
package sclt_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] kind_type;
   typedef logic [2:0] mode_type;

   localparam kind_type K_CHAR   = 4'd0;
   localparam kind_type K_WEND   = 4'd1;
   localparam kind_type K_PIPE   = 4'd2;
   localparam kind_type K_IN     = 4'd3;
   localparam kind_type K_OUT    = 4'd4;
   localparam kind_type K_APPEND = 4'd5;
   localparam kind_type K_BG     = 4'd6;
   localparam kind_type K_END    = 4'd7;
   localparam kind_type K_SQERR  = 4'd8;
   localparam kind_type K_DQERR  = 4'd9;

   localparam mode_type M_IDLE  = 3'd0;
   localparam mode_type M_WORD  = 3'd1;
   localparam mode_type M_SQ    = 3'd2;
   localparam mode_type M_DQ    = 3'd3;
   localparam mode_type M_DQESC = 3'd4;
   localparam mode_type M_ESC   = 3'd5;
   localparam mode_type M_GT    = 3'd6;

   localparam byte_type CH_NUL    = 8'h00;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_PIPE   = 8'h7C;
   localparam byte_type CH_LT     = 8'h3C;
   localparam byte_type CH_GT     = 8'h3E;
   localparam byte_type CH_AMP    = 8'h26;
   localparam byte_type CH_SQUOTE = 8'h27;
   localparam byte_type CH_DQUOTE = 8'h22;
   localparam byte_type CH_BSLASH = 8'h5C;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one queued byte outcome: one or two results
   typedef struct packed {
      logic     two;
      kind_type kind0;
      kind_type kind1;
      byte_type ch;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_space(byte_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

// ----- rtl/sclt_req_if.sv -----
// input channel: one command-line byte per transaction
interface sclt_req_if;
   logic               valid;
   logic               ready;
   sclt_pkg::byte_type line_byte;

   modport source(output valid, output line_byte, input ready);
   modport sink(input valid, input line_byte, output ready);
endinterface

// ----- rtl/sclt_rsp_if.sv -----
// result channel: one token result per transaction
interface sclt_rsp_if;
   logic               valid;
   logic               ready;
   sclt_pkg::kind_type token_kind;
   sclt_pkg::byte_type word_char;
   logic               last_of_run;

   modport source(output valid, output token_kind, output word_char, output last_of_run,
                  input ready);
   modport sink(input valid, input token_kind, input word_char, input last_of_run,
                output ready);
endinterface

// ----- rtl/sclt_front.sv -----
// front end: lexer mode and word length, classifies each byte into queue entries
module sclt_front #(
   parameter int TOKEN_CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   sclt_req_if.sink               req_chan,
   input  sclt_pkg::q_status_type q_stat,
   output logic                   push,
   output sclt_pkg::entry_type    push_entry
);
   import sclt_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_CAPACITY - 1);

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;

   byte_type         c;
   logic             accept;
   logic             can_add;

   mode_type         bt_mode;
   logic [LEN_W-1:0] bt_len;
   logic             bt_emit;
   kind_type         bt_kind;

   logic             use_bt;
   logic             pre;
   kind_type         pre_kind;
   logic             emit;
   logic             two;
   kind_type         k0;
   kind_type         k1;

   assign c              = req_chan.line_byte;
   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign can_add        = (len_ff < LEN_MAX);

   // between-tokens handling of the byte
   always_comb begin
      bt_mode = M_IDLE;
      bt_len  = '0;
      bt_emit = 1'b1;
      bt_kind = K_CHAR;
      if (c == CH_NUL) begin
         bt_kind = K_END;
      end else if (is_space(c)) begin
         bt_emit = 1'b0;
      end else if (c == CH_PIPE) begin
         bt_kind = K_PIPE;
      end else if (c == CH_LT) begin
         bt_kind = K_IN;
      end else if (c == CH_AMP) begin
         bt_kind = K_BG;
      end else if (c == CH_GT) begin
         bt_mode = M_GT;
         bt_emit = 1'b0;
      end else if (c == CH_SQUOTE) begin
         bt_mode = M_SQ;
         bt_emit = 1'b0;
      end else if (c == CH_DQUOTE) begin
         bt_mode = M_DQ;
         bt_emit = 1'b0;
      end else if (c == CH_BSLASH) begin
         bt_mode = M_ESC;
         bt_emit = 1'b0;
      end else begin
         bt_mode = M_WORD;
         bt_len  = LEN_W'(1);
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      use_bt   = 1'b0;
      pre      = 1'b0;
      pre_kind = K_WEND;
      emit     = 1'b0;
      two      = 1'b0;
      k0       = K_CHAR;
      k1       = K_CHAR;
      unique case (mode_ff)
         M_GT: begin
            if (c == CH_GT) begin
               mode_in = M_IDLE;
               emit    = 1'b1;
               k0      = K_APPEND;
            end else begin
               use_bt   = 1'b1;
               pre      = 1'b1;
               pre_kind = K_OUT;
            end
         end
         M_WORD: begin
            if ((c == CH_NUL) || is_space(c) || (c == CH_PIPE) || (c == CH_LT) ||
                (c == CH_GT) || (c == CH_AMP)) begin
               use_bt = 1'b1;
               pre    = 1'b1;
            end else if (c == CH_SQUOTE) begin
               mode_in = M_SQ;
            end else if (c == CH_DQUOTE) begin
               mode_in = M_DQ;
            end else if (c == CH_BSLASH) begin
               mode_in = M_ESC;
            end else if (can_add) begin
               len_in = len_ff + LEN_W'(1);
               emit   = 1'b1;
            end
         end
         M_SQ: begin
            if (c == CH_NUL) begin
               mode_in = M_IDLE;
               len_in  = '0;
               emit    = 1'b1;
               k0      = K_SQERR;
            end else if (c == CH_SQUOTE) begin
               mode_in = M_WORD;
            end else if (can_add) begin
               len_in = len_ff + LEN_W'(1);
               emit   = 1'b1;
            end
         end
         M_DQ: begin
            if (c == CH_NUL) begin
               mode_in = M_IDLE;
               len_in  = '0;
               emit    = 1'b1;
               k0      = K_DQERR;
            end else if (c == CH_DQUOTE) begin
               mode_in = M_WORD;
            end else if (c == CH_BSLASH) begin
               mode_in = M_DQESC;
            end else if (can_add) begin
               len_in = len_ff + LEN_W'(1);
               emit   = 1'b1;
            end
         end
         M_DQESC: begin
            if (c == CH_NUL) begin
               mode_in = M_IDLE;
               len_in  = '0;
               emit    = 1'b1;
               k0      = K_DQERR;
            end else begin
               mode_in = M_DQ;
               if (can_add) begin
                  len_in = len_ff + LEN_W'(1);
                  emit   = 1'b1;
               end
            end
         end
         M_ESC: begin
            if (c == CH_NUL) begin
               use_bt = 1'b1;
               pre    = 1'b1;
            end else begin
               mode_in = M_WORD;
               if (can_add) begin
                  len_in = len_ff + LEN_W'(1);
                  emit   = 1'b1;
               end
            end
         end
         default: begin
            use_bt = 1'b1;
         end
      endcase
      if (use_bt) begin
         mode_in = bt_mode;
         len_in  = bt_len;
         if (pre) begin
            emit = 1'b1;
            k0   = pre_kind;
            if (bt_emit) begin
               two = 1'b1;
               k1  = bt_kind;
            end
         end else begin
            emit = bt_emit;
            k0   = bt_kind;
         end
      end
   end

   assign push             = accept && emit;
   assign push_entry.two   = two;
   assign push_entry.kind0 = k0;
   assign push_entry.kind1 = k1;
   assign push_entry.ch    = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         len_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

endmodule

// ----- rtl/sclt_queue.sv -----
// short entry queue between front end and back end
module sclt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sclt_pkg::entry_type    push_entry,
   input  logic                   pop,
   output sclt_pkg::entry_type    head,
   output sclt_pkg::q_status_type q_stat
);
   import sclt_pkg::*;

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/sclt_back.sv -----
// back end: expands queue entries into results through an output register
module sclt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sclt_pkg::entry_type    head,
   input  sclt_pkg::q_status_type q_stat,
   output logic                   pop,
   sclt_rsp_if.source             rsp_chan
);
   import sclt_pkg::*;

   logic     valid_ff, valid_in;
   logic     second_ff, second_in;
   kind_type kind_ff, kind_in;
   byte_type char_ff, char_in;
   logic     last_ff, last_in;

   logic     out_ld;
   logic     take;

   assign out_ld = !valid_ff || rsp_chan.ready;
   assign take   = out_ld && !q_stat.empty;
   assign pop    = take && (!head.two || second_ff);

   always_comb begin
      kind_in   = second_ff ? head.kind1 : head.kind0;
      char_in   = (kind_in == K_CHAR) ? head.ch : '0;
      last_in   = !head.two || second_ff;
      second_in = second_ff;
      valid_in  = valid_ff;
      if (take) begin
         valid_in  = 1'b1;
         second_in = head.two && !second_ff;
      end else if (out_ld) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.token_kind  = kind_ff;
   assign rsp_chan.word_char   = char_ff;
   assign rsp_chan.last_of_run = last_ff;

endmodule

// ----- rtl/shell_command_line_tokenizer.sv -----
// shell command-line tokenizer top level
//
// req_chan takes one byte of a command line per transaction; byte 0 ends the
// line. rsp_chan gives token results: word characters, word ends, operators
// (| < > >> &), end of line, or a quote error for an unterminated quote.
// last_of_run marks the final result that one input byte causes; a byte may
// cause none, one or two results.
// The front end takes one byte per cycle while its entry queue (four deep)
// has room. The back end drains one result per cycle into the output
// register while rsp_chan is not stalled; a byte with two results uses two
// transactions. Results pass through the entry queue, then the output
// register. A deferred '>' shows its result only with the following byte.
// When the receiver holds rsp_chan.ready low, the output register holds its
// transaction, the queue fills and req_chan.ready drops once it is full.
// Synchronous reset empties the queue and output register and returns the
// lexer to the between-tokens mode with an empty word.
module shell_command_line_tokenizer #(
   parameter int TOKEN_CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   sclt_req_if.sink   req_chan,
   sclt_rsp_if.source rsp_chan
);
   import sclt_pkg::*;

   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head;
   q_status_type q_stat;

   sclt_front #(
      .TOKEN_CAPACITY(TOKEN_CAPACITY)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_stat    (q_stat),
      .push      (push),
      .push_entry(push_entry)
   );

   sclt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   sclt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_chan(rsp_chan)
   );

`ifndef SYNTHESIS
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_chan.ready)
      else $error("input taken while queue full");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run
      |=> rsp_chan.valid && rsp_chan.last_of_run)
      else $error("second result of a byte missing");

   a_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_of_run
      |-> (rsp_chan.token_kind == K_OUT) || (rsp_chan.token_kind == K_WEND))
      else $error("unexpected kind on first of two results");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the shell command-line tokenizer
`timescale 1ns / 1ps

module tb;
   import sclt_pkg::*;

   localparam int TOKEN_CAPACITY = 64;
   localparam int STALL_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int TAIL_CYCLES    = 10;
   localparam int PHASE_ITEMS    = 150;
   localparam int N_DIRECTED     = 25;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      kind_type kind;
      byte_type ch;
      logic     last;
   } token_rec_type;

   typedef struct packed {
      byte_type   b;
      logic       typed;
      logic [1:0] n;
      kind_type   k0;
      byte_type   c0;
      kind_type   k1;
      byte_type   c1;
   } stim_row_type;

   logic clock;
   logic reset;

   sclt_req_if req_chan ();
   sclt_rsp_if rsp_chan ();

   shell_command_line_tokenizer #(.TOKEN_CAPACITY(TOKEN_CAPACITY)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   token_rec_type expected_tokens[$];
   token_rec_type byte_tokens[$];
   mode_type lex_state;
   int       word_len;

   int mismatches  = 0;
   int bytes_sent  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_trigger = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int quiet_cycles = 0;

   // typed rows: byte, typed, count, kind0, char0, kind1, char1
   stim_row_type directed [N_DIRECTED] = '{
      '{CH_NUL,    1'b1, 2'd1, K_END,    8'h00, K_CHAR, 8'h00},
      '{CH_PIPE,   1'b1, 2'd1, K_PIPE,   8'h00, K_CHAR, 8'h00},
      '{CH_LT,     1'b1, 2'd1, K_IN,     8'h00, K_CHAR, 8'h00},
      '{CH_AMP,    1'b1, 2'd1, K_BG,     8'h00, K_CHAR, 8'h00},
      '{CH_GT,     1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_GT,     1'b1, 2'd1, K_APPEND, 8'h00, K_CHAR, 8'h00},
      '{CH_GT,     1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{8'h61,     1'b1, 2'd2, K_OUT,    8'h00, K_CHAR, 8'h61},
      '{8'hFF,     1'b1, 2'd1, K_CHAR,   8'hFF, K_CHAR, 8'h00},
      '{CH_TAB,    1'b1, 2'd1, K_WEND,   8'h00, K_CHAR, 8'h00},
      '{8'h80,     1'b0, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_SQUOTE, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_SPACE,  1'b0, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_NUL,    1'b1, 2'd1, K_SQERR,  8'h00, K_CHAR, 8'h00},
      '{CH_DQUOTE, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_BSLASH, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_NUL,    1'b1, 2'd1, K_DQERR,  8'h00, K_CHAR, 8'h00},
      '{CH_BSLASH, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_NUL,    1'b1, 2'd2, K_WEND,   8'h00, K_END,  8'h00},
      '{CH_SQUOTE, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_SQUOTE, 1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_CR,     1'b1, 2'd1, K_WEND,   8'h00, K_CHAR, 8'h00},
      '{CH_GT,     1'b1, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{8'h7A,     1'b0, 2'd0, K_CHAR,   8'h00, K_CHAR, 8'h00},
      '{CH_NUL,    1'b1, 2'd2, K_WEND,   8'h00, K_END,  8'h00}
   };

   int phase_idle  [4] = '{0, 68, 0, 30};
   int phase_stall [4] = '{0, 0, 68, 30};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // tokenizer prediction

   function automatic bit blank(byte_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic void emit(kind_type k, byte_type c);
      token_rec_type t;
      t.kind = k;
      t.ch   = (k == K_CHAR) ? c : 8'h00;
      t.last = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   function automatic void keep_char(byte_type c);
      if (word_len < TOKEN_CAPACITY - 1) begin
         word_len++;
         emit(K_CHAR, c);
      end
   endfunction

   function automatic void quote_error(kind_type k);
      lex_state = M_IDLE;
      word_len  = 0;
      emit(k, 8'h00);
   endfunction

   function automatic void start_token(byte_type c);
      lex_state = M_IDLE;
      word_len  = 0;
      case (c)
         CH_NUL:    emit(K_END, 8'h00);
         CH_PIPE:   emit(K_PIPE, 8'h00);
         CH_LT:     emit(K_IN, 8'h00);
         CH_AMP:    emit(K_BG, 8'h00);
         CH_GT:     lex_state = M_GT;
         CH_SQUOTE: lex_state = M_SQ;
         CH_DQUOTE: lex_state = M_DQ;
         CH_BSLASH: lex_state = M_ESC;
         default: begin
            if (!blank(c)) begin
               lex_state = M_WORD;
               keep_char(c);
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(byte_type c);
      byte_tokens.delete();
      case (lex_state)
         M_GT: begin
            if (c == CH_GT) begin
               lex_state = M_IDLE;
               emit(K_APPEND, 8'h00);
            end else begin
               emit(K_OUT, 8'h00);
               start_token(c);
            end
         end
         M_WORD: begin
            if (c == CH_NUL || blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT ||
                c == CH_AMP) begin
               emit(K_WEND, 8'h00);
               start_token(c);
            end else if (c == CH_SQUOTE) lex_state = M_SQ;
            else if (c == CH_DQUOTE) lex_state = M_DQ;
            else if (c == CH_BSLASH) lex_state = M_ESC;
            else keep_char(c);
         end
         M_SQ: begin
            if (c == CH_NUL) quote_error(K_SQERR);
            else if (c == CH_SQUOTE) lex_state = M_WORD;
            else keep_char(c);
         end
         M_DQ: begin
            if (c == CH_NUL) quote_error(K_DQERR);
            else if (c == CH_DQUOTE) lex_state = M_WORD;
            else if (c == CH_BSLASH) lex_state = M_DQESC;
            else keep_char(c);
         end
         M_DQESC: begin
            if (c == CH_NUL) quote_error(K_DQERR);
            else begin
               lex_state = M_DQ;
               keep_char(c);
            end
         end
         M_ESC: begin
            if (c == CH_NUL) begin
               emit(K_WEND, 8'h00);
               start_token(c);
            end else begin
               lex_state = M_WORD;
               keep_char(c);
            end
         end
         default: start_token(c);
      endcase
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
   endfunction

   // input channel

   task automatic send_byte(byte_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.line_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic offer_byte(byte_type b);
      send_byte(b);
      lex_byte(b);
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // random command lines

   function automatic byte_type word_byte();
      byte_type c;
      do c = byte_type'($urandom_range(1, 255));
      while (blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP ||
             c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic byte_type blank_byte();
      if ($urandom_range(1) == 0) return CH_SPACE;
      return byte_type'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic byte_type quoted_byte(byte_type closer);
      byte_type c;
      do c = byte_type'($urandom_range(1, 255));
      while (c == closer || c == CH_BSLASH && closer == CH_DQUOTE);
      return c;
   endfunction

   task automatic send_word(int len);
      int left;
      int k;
      int pick;
      left = len;
      while (left > 0) begin
         pick = $urandom_range(9);
         k    = $urandom_range(1, (left < 4) ? left : 4);
         if (pick <= 4) begin
            repeat (k) offer_byte(word_byte());
         end else if (pick <= 6) begin
            offer_byte(CH_SQUOTE);
            if ($urandom_range(5) != 0) repeat (k) offer_byte(quoted_byte(CH_SQUOTE));
            offer_byte(CH_SQUOTE);
         end else if (pick <= 8) begin
            offer_byte(CH_DQUOTE);
            repeat (k) begin
               if ($urandom_range(4) == 0) begin
                  offer_byte(CH_BSLASH);
                  offer_byte(byte_type'($urandom_range(1, 255)));
               end else offer_byte(quoted_byte(CH_DQUOTE));
            end
            offer_byte(CH_DQUOTE);
         end else begin
            k = 1;
            offer_byte(CH_BSLASH);
            offer_byte(byte_type'($urandom_range(1, 255)));
         end
         left -= k;
      end
   endtask

   task automatic send_line();
      int tail;
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(1, 12)) offer_byte(byte_type'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 5)) begin
            repeat ($urandom_range(0, 2)) offer_byte(blank_byte());
            if ($urandom_range(9) < 3) begin
               case ($urandom_range(4))
                  0: offer_byte(CH_PIPE);
                  1: offer_byte(CH_LT);
                  2: offer_byte(CH_GT);
                  3: begin
                     offer_byte(CH_GT);
                     offer_byte(CH_GT);
                  end
                  default: offer_byte(CH_AMP);
               endcase
            end else begin
               if ($urandom_range(24) == 0) send_word($urandom_range(58, 72));
               else send_word($urandom_range(1, 8));
            end
         end
         tail = $urandom_range(9);
         if (tail == 0) begin
            offer_byte(CH_SQUOTE);
            repeat ($urandom_range(0, 3)) offer_byte(quoted_byte(CH_SQUOTE));
         end else if (tail == 1) begin
            offer_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 3)) offer_byte(quoted_byte(CH_DQUOTE));
            if ($urandom_range(1) == 0) offer_byte(CH_BSLASH);
         end else if (tail == 2) begin
            offer_byte(CH_BSLASH);
         end else begin
            repeat ($urandom_range(0, 1)) offer_byte(blank_byte());
         end
         offer_byte(CH_NUL);
      end
   endtask

   // result channel

   always @(posedge clock) begin
      if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
   endfunction

   always @(posedge clock) begin : check_results
      token_rec_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("unexpected transaction: kind %0d char %02h last %0b",
                                    rsp_chan.token_kind, rsp_chan.word_char,
                                    rsp_chan.last_of_run));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_chan.token_kind !== want.kind || rsp_chan.word_char !== want.ch ||
                rsp_chan.last_of_run !== want.last)
               note_mismatch($sformatf(
                  "token mismatch: expected kind %0d char %02h last %0b, got %0d %02h %0b",
                  want.kind, want.ch, want.last, rsp_chan.token_kind, rsp_chan.word_char,
                  rsp_chan.last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      token_rec_type t;
      int target;
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.line_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      lex_state          = M_IDLE;
      word_len           = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            send_byte(directed[i].b);
            lex_byte(directed[i].b);
            for (int j = 0; j < directed[i].n; j++) begin
               t.kind = (j == 0) ? directed[i].k0 : directed[i].k1;
               t.ch   = (j == 0) ? directed[i].c0 : directed[i].c1;
               t.last = (j == directed[i].n - 1);
               expected_tokens.push_back(t);
            end
         end else begin
            offer_byte(directed[i].b);
         end
      end
      settle();

      target = bytes_sent;
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == 0) hold_trigger++;
         target += PHASE_ITEMS;
         while (bytes_sent < target) send_line();
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
